// ===== rtl/deq_pkg.sv =====
// Package for the double-ended queue: sizes, codes and the transfer payload types.
// Used by double_ended_queue_top; depends on nothing else.
package deq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
    logic [6:0]         occupancy;
  } rsp_t;

endpackage

// ===== rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue of signed words kept in a ring buffer memory.
// A request is taken in S_IDLE, which updates the pointers and writes the slot; S_READ reads
// the memory; S_LOAD loads the response register and raises rsp_valid once no stalled
// response is pending. req_stall holds off new requests until the machine is back in S_IDLE.
// Reset clears the pointers, the count and the state machine; slot memory is not cleared.
// Depends on deq_pkg.
module double_ended_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [31:0] mem [deq_pkg::CAPACITY];

  logic [deq_pkg::IDX_W-1:0] head, head_next;
  logic [deq_pkg::IDX_W-1:0] tail, tail_next;
  logic [deq_pkg::CNT_W-1:0] count, count_next;
  deq_pkg::status_t          status, status_next;

  logic                      wr_en;
  logic [deq_pkg::IDX_W-1:0] wr_addr;
  logic [31:0]               rd_front;
  logic [31:0]               rd_rear;

  logic accept;
  logic full;
  logic empty;
  logic load;

  function automatic logic [deq_pkg::IDX_W-1:0] wrap_inc(
    input logic [deq_pkg::IDX_W-1:0] i
  );
    if (i == deq_pkg::IDX_W'(deq_pkg::CAPACITY - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  function automatic logic [deq_pkg::IDX_W-1:0] wrap_dec(
    input logic [deq_pkg::IDX_W-1:0] i
  );
    if (i == '0) begin
      return deq_pkg::IDX_W'(deq_pkg::CAPACITY - 1);
    end
    return i - 1'b1;
  endfunction

  assign req_stall = rst || (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
  assign empty     = (count == '0);
  assign load      = (state == S_LOAD) && (!rsp_valid || !rsp_stall);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = status;
    wr_en       = 1'b0;
    wr_addr     = tail;
    if (accept) begin
      status_next = deq_pkg::ST_OK;
      case (deq_pkg::op_t'(req.operation))
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_next = deq_pkg::ST_OVERFLOW;
          end else begin
            head_next  = wrap_dec(head);
            wr_en      = 1'b1;
            wr_addr    = wrap_dec(head);
            count_next = count + 1'b1;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_next = deq_pkg::ST_OVERFLOW;
          end else begin
            tail_next  = wrap_inc(tail);
            wr_en      = 1'b1;
            wr_addr    = tail;
            count_next = count + 1'b1;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_next = deq_pkg::ST_UNDERFLOW;
          end else begin
            head_next  = wrap_inc(head);
            count_next = count - 1'b1;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_next = deq_pkg::ST_UNDERFLOW;
          end else begin
            tail_next  = wrap_dec(tail);
            count_next = count - 1'b1;
          end
        end
        default: begin
          status_next = status;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      status    <= deq_pkg::ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      status <= status_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_front <= mem[head];
      rd_rear  <= mem[wrap_dec(tail)];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status      <= status;
      rsp.front_value <= empty ? '0 : rd_front;
      rsp.rear_value  <= empty ? '0 : rd_rear;
      rsp.is_empty    <= empty;
      rsp.is_full     <= full;
      rsp.occupancy   <= 7'(count);
    end
  end

endmodule
